FILE: sv/integer_to_ascii_converter_macros.svh
// Assertion macros for the integer to ASCII converter.
// Included by the top level; needs nothing else.
`ifndef INTEGER_TO_ASCII_CONVERTER_MACROS_SVH
`define INTEGER_TO_ASCII_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define IAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("integer_to_ascii_converter: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define IAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("integer_to_ascii_converter: next-cycle check failed");

`endif

FILE: sv/iac_pkg.sv
// Shared constants, types and the digit character table of the converter.
// Depends on nothing; used by iac_dabble and integer_to_ascii_converter.
package iac_pkg;

    // Value width used from the input word, and the longest text emitted.
    localparam int VALUE_BITS = 64;
    localparam int MAX_CHARS  = 20;

    // Digit slots of the conversion register; 20 decimal digits cover 64 bits.
    localparam int DIGITS     = 20;
    localparam int DIGIT_BITS = DIGITS * 4;

    // Counter widths.
    localparam int BITS_W  = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W  = $clog2(DIGITS + 1);
    localparam int NCHAR_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

    // Mode codes carried in the input tuser.
    localparam logic [1:0] OP_SIGNED   = 2'd0;
    localparam logic [1:0] OP_UNSIGNED = 2'd1;
    localparam logic [1:0] OP_HEX      = 2'd2;

    // Fixed characters of the text.
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_X     = 7'h78;

    typedef logic [DIGITS-1:0][3:0] t_digits;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SKIP,
        ST_PFX0,
        ST_PFX1,
        ST_DIGIT
    } t_state;

    // Upper-case character for one digit value.
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        case (d)
            4'h0: c = 7'h30;
            4'h1: c = 7'h31;
            4'h2: c = 7'h32;
            4'h3: c = 7'h33;
            4'h4: c = 7'h34;
            4'h5: c = 7'h35;
            4'h6: c = 7'h36;
            4'h7: c = 7'h37;
            4'h8: c = 7'h38;
            4'h9: c = 7'h39;
            4'hA: c = 7'h41;
            4'hB: c = 7'h42;
            4'hC: c = 7'h43;
            4'hD: c = 7'h44;
            4'hE: c = 7'h45;
            default: c = 7'h46;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/iac_dabble.sv
// One step of the shift-and-add-3 binary to digit conversion.
// Depends on iac_pkg for the digit register type and its size.
module iac_dabble (
    input  iac_pkg::t_digits i_digits,
    input  logic             i_bit,
    input  logic             i_hex,
    output iac_pkg::t_digits o_digits
);

    iac_pkg::t_digits                  w_adj;
    logic [iac_pkg::DIGIT_BITS-1:0]    w_flat;

    // In decimal mode every digit of five or more is corrected by three
    // before the shift; in hex mode the register is a plain shift line.
    always_comb begin
        for (int i = 0; i < iac_pkg::DIGITS; i++) begin
            if (!i_hex && (i_digits[i] >= 4'd5)) begin
                w_adj[i] = i_digits[i] + 4'd3;
            end else begin
                w_adj[i] = i_digits[i];
            end
        end
        w_flat   = w_adj;
        o_digits = {w_flat[iac_pkg::DIGIT_BITS-2:0], i_bit};
    end

endmodule

FILE: sv/integer_to_ascii_converter.sv
// Integer to ASCII converter: top level with sequencer and output stage.
// Depends on iac_pkg, iac_dabble and integer_to_ascii_converter_macros.svh.
//
// Usage: the slave channel takes one word per conversion, the value in
// s_axis_tdata and the mode in s_axis_tuser (signed decimal, unsigned
// decimal, or hexadecimal with a "0x" prefix; the unused mode code acts as
// unsigned decimal). The master channel returns the text one ASCII character
// per word, most significant first, with m_axis_tlast on the final one.
// s_axis_tready is high only while the block is idle.
// Timing: after a word is accepted the shared conversion unit runs one bit
// per cycle through all 64 value bits, then leading zero digits are dropped
// one per cycle, then one character is offered per cycle while m_axis_tready
// is high. A new word is taken only once the final character has been sent.
// A stall on m_axis_tready holds the current character and pauses the
// sequencer. Reset returns the block to idle and drops any text in flight.
`include "integer_to_ascii_converter_macros.svh"

module integer_to_ascii_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] text_char, [7] zero
    output logic        m_axis_tlast    // last
);

    iac_pkg::t_state                  r_state, n_state;
    logic [iac_pkg::VALUE_BITS-1:0]   r_shift, n_shift;
    iac_pkg::t_digits                 r_digits, n_digits;
    logic [iac_pkg::BITS_W-1:0]       r_bits, n_bits;
    logic [iac_pkg::LEFT_W-1:0]       r_left, n_left;
    logic [iac_pkg::NCHAR_W-1:0]      r_nchar, n_nchar;
    logic                             r_hex, n_hex;
    logic                             r_neg, n_neg;

    logic [iac_pkg::VALUE_BITS-1:0]   w_value;
    logic                             w_in_neg;
    iac_pkg::t_digits                 w_step;
    logic                             w_in_acc;
    logic                             w_out_acc;
    logic                             w_last;
    logic                             w_skip;
    logic [6:0]                       w_char;

    assign w_value   = s_axis_tdata[iac_pkg::VALUE_BITS-1:0];
    assign w_in_neg  = (s_axis_tuser == iac_pkg::OP_SIGNED) && w_value[iac_pkg::VALUE_BITS-1];
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    // Shared conversion step fed by the top bit of the shift register.
    iac_dabble u_dabble (
        .i_digits (r_digits),
        .i_bit    (r_shift[iac_pkg::VALUE_BITS-1]),
        .i_hex    (r_hex),
        .o_digits (w_step)
    );

    // A leading zero digit is dropped while more than one digit is left.
    assign w_skip = (r_digits[iac_pkg::DIGITS-1] == 4'd0) && (r_left > iac_pkg::LEFT_W'(1));

    // The character in flight ends the text at the last digit or at the length cap.
    assign w_last = (r_nchar == iac_pkg::NCHAR_W'(iac_pkg::MAX_CHARS - 1))
                 || ((r_state == iac_pkg::ST_DIGIT) && (r_left == iac_pkg::LEFT_W'(1)));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iac_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = iac_pkg::ST_SHIFT;
                end
            end
            iac_pkg::ST_SHIFT: begin
                if (r_bits == iac_pkg::BITS_W'(1)) begin
                    n_state = iac_pkg::ST_SKIP;
                end
            end
            iac_pkg::ST_SKIP: begin
                if (!w_skip) begin
                    n_state = (r_hex || r_neg) ? iac_pkg::ST_PFX0 : iac_pkg::ST_DIGIT;
                end
            end
            iac_pkg::ST_PFX0: begin
                if (w_out_acc) begin
                    if (w_last) begin
                        n_state = iac_pkg::ST_IDLE;
                    end else begin
                        n_state = r_hex ? iac_pkg::ST_PFX1 : iac_pkg::ST_DIGIT;
                    end
                end
            end
            iac_pkg::ST_PFX1: begin
                if (w_out_acc) begin
                    n_state = w_last ? iac_pkg::ST_IDLE : iac_pkg::ST_DIGIT;
                end
            end
            iac_pkg::ST_DIGIT: begin
                if (w_out_acc && w_last) begin
                    n_state = iac_pkg::ST_IDLE;
                end
            end
            default: n_state = iac_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_char        = iac_pkg::CH_ZERO;
        n_shift       = r_shift;
        n_digits      = r_digits;
        n_bits        = r_bits;
        n_left        = r_left;
        n_nchar       = r_nchar;
        n_hex         = r_hex;
        n_neg         = r_neg;
        unique case (r_state)
            iac_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                n_shift       = w_in_neg ? (~w_value + 1'b1) : w_value;
                n_digits      = '0;
                n_bits        = iac_pkg::BITS_W'(iac_pkg::VALUE_BITS);
                n_left        = iac_pkg::LEFT_W'(iac_pkg::DIGITS);
                n_nchar       = '0;
                n_hex         = (s_axis_tuser == iac_pkg::OP_HEX);
                n_neg         = w_in_neg;
            end
            iac_pkg::ST_SHIFT: begin
                n_digits = w_step;
                n_shift  = {r_shift[iac_pkg::VALUE_BITS-2:0], 1'b0};
                n_bits   = r_bits - 1'b1;
            end
            iac_pkg::ST_SKIP: begin
                if (w_skip) begin
                    n_digits = {r_digits[iac_pkg::DIGITS-2:0], 4'd0};
                    n_left   = r_left - 1'b1;
                end
            end
            iac_pkg::ST_PFX0: begin
                m_axis_tvalid = 1'b1;
                w_char        = r_hex ? iac_pkg::CH_ZERO : iac_pkg::CH_MINUS;
                if (w_out_acc) begin
                    n_nchar = r_nchar + 1'b1;
                end
            end
            iac_pkg::ST_PFX1: begin
                m_axis_tvalid = 1'b1;
                w_char        = iac_pkg::CH_X;
                if (w_out_acc) begin
                    n_nchar = r_nchar + 1'b1;
                end
            end
            iac_pkg::ST_DIGIT: begin
                m_axis_tvalid = 1'b1;
                w_char        = iac_pkg::digit_char(r_digits[iac_pkg::DIGITS-1]);
                if (w_out_acc && !w_last) begin
                    n_nchar  = r_nchar + 1'b1;
                    n_digits = {r_digits[iac_pkg::DIGITS-2:0], 4'd0};
                    n_left   = r_left - 1'b1;
                end
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign m_axis_tdata = {1'b0, w_char};
    assign m_axis_tlast = w_last;

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iac_pkg::ST_IDLE;
            r_bits  <= '0;
            r_left  <= '0;
            r_nchar <= '0;
        end else begin
            r_state <= n_state;
            r_bits  <= n_bits;
            r_left  <= n_left;
            r_nchar <= n_nchar;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_shift  <= n_shift;
        r_digits <= n_digits;
        r_hex    <= n_hex;
        r_neg    <= n_neg;
    end

    // Checks on the sequencer and the conversion unit.
    `IAC_ASSERT_NOW(a_one_side, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    `IAC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !s_axis_tready && (r_state == iac_pkg::ST_SHIFT))
    `IAC_ASSERT_NOW(a_decimal_digit, i_clk, i_rst_n, (r_state == iac_pkg::ST_DIGIT) && !r_hex, r_digits[iac_pkg::DIGITS-1] <= 4'd9)

endmodule

FILE: tb/integer_to_ascii_converter_tb.sv
// Testbench for the integer to ASCII converter: drives values and modes on the
// input stream and checks every text word against a predicted character queue.
// Depends on iac_pkg and the integer_to_ascii_converter top level.
`timescale 1ns / 1ps

module integer_to_ascii_converter_tb;

    // The spare mode code, which the block treats as unsigned decimal.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Cycles with no accepted word before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 3000;
    // Quiet cycles after the last expected word, longer than one conversion.
    localparam int DRAIN_CYCLES   = 120;
    // Length of the one long hold on the output side.
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 136;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_text_char;

    // Predicts the text of each accepted value and checks the output words.
    class ascii_text_checker;
        t_text_char pending_chars[$];
        int         mismatches;

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        // Builds the expected characters for one value and mode.
        function void predict_text(logic [1:0] op, logic [63:0] value);
            logic [63:0] mag;
            logic [63:0] radix;
            logic [3:0]  digit;
            logic [6:0]  line[$];
            logic [3:0]  digits[$];
            string       digit_set;
            bit          negative;
            int          n;
            digit_set = "0123456789ABCDEF";
            mag       = value;
            negative  = 1'b0;
            if (op == iac_pkg::OP_SIGNED && value[63]) begin
                negative = 1'b1;
                mag      = 64'd0 - value;
            end
            radix = (op == iac_pkg::OP_HEX) ? 64'd16 : 64'd10;
            // Digits come out least significant first; zero still gives one.
            do begin
                digit = 4'(mag % radix);
                digits.push_front(digit);
                mag = mag / radix;
            end while (mag != 64'd0);
            if (op == iac_pkg::OP_HEX) begin
                line.push_back(iac_pkg::CH_ZERO);
                line.push_back(iac_pkg::CH_X);
            end else if (negative) begin
                line.push_back(iac_pkg::CH_MINUS);
            end
            foreach (digits[i]) begin
                line.push_back(7'(digit_set[digits[i]]));
            end
            n = (line.size() > iac_pkg::MAX_CHARS) ? iac_pkg::MAX_CHARS : line.size();
            for (int k = 0; k < n; k++) begin
                pending_chars.push_back('{ch: line[k], last: (k == n - 1)});
            end
        endfunction

        // Checks one output word against the oldest expected character.
        function void compare_char(logic [7:0] data, logic last);
            t_text_char want;
            if (pending_chars.size() == 0) begin
                report($sformatf("word with no text pending: data %h last %b", data, last));
                return;
            end
            want = pending_chars.pop_front();
            if (data !== {1'b0, want.ch} || last !== want.last) begin
                report($sformatf("expected data %h last %b, got data %h last %b",
                                 {1'b0, want.ch}, want.last, data, last));
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = 64'd0;   // [63:0] value
    logic [1:0]  s_axis_tuser  = 2'd0;    // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;            // [6:0] text_char, [7] zero
    logic        m_axis_tlast;            // last

    ascii_text_checker board = new();

    bit no_idle     = 1'b0;
    int rx_hold_len = 0;
    int idle_cycles = 0;

    integer_to_ascii_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Monitor both streams at the rising edge and keep the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                board.compare_char(m_axis_tdata, m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                board.predict_text(s_axis_tuser, s_axis_tdata);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Output side: a random stall before each word, or the one long hold.
    initial begin
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (rx_hold_len > 0) begin
                stall       = rx_hold_len;
                rx_hold_len = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Offers one word after a random gap and returns at the next falling edge.
    task automatic offer_word(input logic [1:0] op, input logic [63:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stops offering until every predicted character has been seen.
    task automatic drain_text();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (board.outstanding() != 0);
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        int          k;
        k = $urandom_range(0, 19);
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 20));
            2: begin
                // Around a power of ten, where the digit count changes.
                v = 64'd1;
                repeat (k) v = v * 64'd10;
                v = v + $urandom_range(0, 2) - 1;
            end
            3: v = (64'd1 << $urandom_range(0, 63)) + $urandom_range(0, 2) - 1;
            4: v = 64'd0 - $urandom_range(0, 1000);
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    function automatic logic [1:0] rand_op();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return iac_pkg::OP_SIGNED;
        end else if (r < 6) begin
            return iac_pkg::OP_UNSIGNED;
        end else if (r < 9) begin
            return iac_pkg::OP_HEX;
        end
        return OP_SPARE;
    endfunction

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero and full-scale in every mode, the most negative
        // value, digit-count boundaries and all hex digits.
        offer_word(iac_pkg::OP_SIGNED,   64'd0);
        offer_word(iac_pkg::OP_UNSIGNED, 64'd0);
        offer_word(iac_pkg::OP_HEX,      64'd0);
        offer_word(OP_SPARE,             64'd0);
        offer_word(iac_pkg::OP_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF);
        offer_word(iac_pkg::OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
        offer_word(iac_pkg::OP_HEX,      64'hFFFF_FFFF_FFFF_FFFF);
        offer_word(OP_SPARE,             64'hFFFF_FFFF_FFFF_FFFF);
        offer_word(iac_pkg::OP_SIGNED,   64'h8000_0000_0000_0000);
        offer_word(iac_pkg::OP_UNSIGNED, 64'h8000_0000_0000_0000);
        offer_word(iac_pkg::OP_HEX,      64'h8000_0000_0000_0000);
        offer_word(iac_pkg::OP_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF);
        offer_word(iac_pkg::OP_SIGNED,   64'd1);
        offer_word(iac_pkg::OP_SIGNED,   64'hFFFF_FFFF_FFFF_FFF6);
        offer_word(iac_pkg::OP_UNSIGNED, 64'd9);
        offer_word(iac_pkg::OP_UNSIGNED, 64'd10);
        offer_word(iac_pkg::OP_HEX,      64'd15);
        offer_word(iac_pkg::OP_HEX,      64'd16);
        offer_word(iac_pkg::OP_UNSIGNED, 64'd9999999999999999999);
        offer_word(iac_pkg::OP_UNSIGNED, 64'd10000000000000000000);
        offer_word(iac_pkg::OP_SIGNED,   64'd9876543210123456789);
        offer_word(iac_pkg::OP_HEX,      64'h0123_4567_89AB_CDEF);
        offer_word(iac_pkg::OP_HEX,      64'hFEDC_BA98_7654_3210);
        offer_word(OP_SPARE,             64'd1234567890);
        drain_text();

        // Random: one long output hold, one stretch without gaps, one pause.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 90 && i < 120);
            if (i == 40) begin
                rx_hold_len = LONG_HOLD;
            end
            if (i == 130) begin
                drain_text();
            end
            offer_word(rand_op(), rand_value());
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (board.outstanding() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
